// ===== hdl/cttq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection timeout timer queue package
// Shared command and result codes, field widths and the cell write bundle.
// ----------------------------------------------------------------------------
package cttq_pkg;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 6;
  localparam int TMO_W  = 24;
  localparam int TIME_W = 48;
  localparam int KIND_W = 2;
  localparam int LEFT_W = 25;
  localparam int MAX_OUT = 64;
  localparam int NUM_W  = 7;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd2;

  localparam logic [TMO_W-1:0] MAX_LEFT = '1;

  typedef struct packed {
    logic              en;
    logic              arm;
    logic [TIME_W-1:0] deadline;
  } cell_wr_t;

endpackage

// ===== hdl/cttq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer request channel
// Valid/ready channel carrying one timer command per request.
// ----------------------------------------------------------------------------
interface cttq_req_if;
  logic                        valid;
  logic                        ready;
  logic [cttq_pkg::CMD_W-1:0]  cmd;
  logic [cttq_pkg::SLOT_W-1:0] conn_slot;
  logic [cttq_pkg::TMO_W-1:0]  timeout_ms;
  logic [cttq_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, cmd, conn_slot, timeout_ms, now_ms, input ready);
  modport sink (input valid, cmd, conn_slot, timeout_ms, now_ms, output ready);
endinterface

// ===== hdl/cttq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer result channel
// Valid/ready channel carrying timer results; last marks a request's final one.
// ----------------------------------------------------------------------------
interface cttq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [cttq_pkg::KIND_W-1:0]        result_kind;
  logic [cttq_pkg::SLOT_W-1:0]        expired_slot;
  logic signed [cttq_pkg::LEFT_W-1:0] ms_to_next;
  logic                               last;

  modport source (output valid, result_kind, expired_slot, ms_to_next, last,
                  input ready);
  modport sink (input valid, result_kind, expired_slot, ms_to_next, last,
                output ready);
endinterface

// ===== hdl/cttq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer cell
// Holds one slot's deadline and armed bit and passes on the earliest timer
// seen so far along the chain, one cell per cycle.
// ----------------------------------------------------------------------------
module cttq_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cttq_pkg::cell_wr_t          wr,
  input  logic                        in_valid,
  input  logic [cttq_pkg::TIME_W-1:0] in_deadline,
  input  logic [IW-1:0]               in_idx,
  output logic                        out_valid,
  output logic [cttq_pkg::TIME_W-1:0] out_deadline,
  output logic [IW-1:0]               out_idx
);

  logic                        armed;
  logic [cttq_pkg::TIME_W-1:0] deadline;
  logic                        take_own;

  assign take_own = armed && (!in_valid || (deadline < in_deadline));

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        armed <= wr.arm;
      end
      out_valid <= in_valid || armed;
    end
    if (wr.en && wr.arm) begin
      deadline <= wr.deadline;
    end
    if (take_own) begin
      out_deadline <= deadline;
      out_idx      <= IW'(IDX);
    end else begin
      out_deadline <= in_deadline;
      out_idx      <= in_idx;
    end
  end

endmodule

// ===== hdl/connection_timeout_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection timeout timer queue
// Per-slot deadlines in a chain of cells; expire and query search the chain.
// ----------------------------------------------------------------------------
// Add and delete write their cell when accepted. Query searches the whole chain,
// then holds its result for output. Expire searches once per fired timer plus
// one final search, the cell chain carrying the earliest deadline one cell per cycle.
// Synchronous reset disarms every slot; deadlines need no clearing.
module connection_timeout_timer_queue #(
  parameter int SLOTS = 64
) (
  input logic       clk,
  input logic       rst,
  cttq_req_if.sink  req,
  cttq_rsp_if.source rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW = (IW > cttq_pkg::SLOT_W) ? IW : cttq_pkg::SLOT_W;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  state_t                      state;
  logic [CW-1:0]               cnt;
  logic [cttq_pkg::CMD_W-1:0]  cmd_r;
  logic [cttq_pkg::TIME_W-1:0] now_r;
  logic [cttq_pkg::NUM_W-1:0]  num;
  logic                        pend;
  logic [IW-1:0]               pend_idx;
  logic                        fin;

  logic [cttq_pkg::KIND_W-1:0]        kind_r;
  logic [cttq_pkg::SLOT_W-1:0]        slot_r;
  logic signed [cttq_pkg::LEFT_W-1:0] left_r;
  logic                               last_r;

  logic                        c_valid [SLOTS+1];
  logic [cttq_pkg::TIME_W-1:0] c_dl    [SLOTS+1];
  logic [IW-1:0]               c_idx   [SLOTS+1];

  logic                        accept;
  logic                        scan_done;
  logic                        found;
  logic                        wr_en;
  logic [SW-1:0]               wr_idx;
  logic                        wr_arm;
  logic [cttq_pkg::TIME_W:0]   sum;
  logic [cttq_pkg::TIME_W-1:0] sum_sat;
  logic [cttq_pkg::TIME_W-1:0] diff;
  logic                        b_valid;
  logic [cttq_pkg::TIME_W-1:0] b_dl;
  logic [IW-1:0]               b_idx;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp.valid        = (state == S_OUT);
  assign rsp.result_kind  = kind_r;
  assign rsp.expired_slot = slot_r;
  assign rsp.ms_to_next   = left_r;
  assign rsp.last         = last_r;

  assign b_valid   = c_valid[SLOTS];
  assign b_dl      = c_dl[SLOTS];
  assign b_idx     = c_idx[SLOTS];
  assign scan_done = (state == S_SCAN) && (cnt == CW'(SLOTS));
  assign found     = b_valid && (b_dl <= now_r) && (num < cttq_pkg::NUM_W'(cttq_pkg::MAX_OUT));
  assign diff      = b_dl - now_r;

  assign sum     = {1'b0, req.now_ms} + (cttq_pkg::TIME_W + 1)'(req.timeout_ms);
  assign sum_sat = sum[cttq_pkg::TIME_W] ? '1 : sum[cttq_pkg::TIME_W-1:0];

  always_comb begin
    wr_en  = 1'b0;
    wr_arm = 1'b0;
    wr_idx = SW'(req.conn_slot);
    if (accept && (32'(req.conn_slot) < SLOTS) &&
        ((req.cmd == cttq_pkg::CMD_ADD) || (req.cmd == cttq_pkg::CMD_DELETE))) begin
      wr_en  = 1'b1;
      wr_arm = (req.cmd == cttq_pkg::CMD_ADD);
    end else if (scan_done && (cmd_r == cttq_pkg::CMD_EXPIRE) && found) begin
      wr_en  = 1'b1;
      wr_idx = SW'(b_idx);
    end
  end

  assign c_valid[0] = 1'b0;
  assign c_dl[0]    = '0;
  assign c_idx[0]   = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cttq_pkg::cell_wr_t wr;
    assign wr.en       = wr_en && (wr_idx == SW'(i));
    assign wr.arm      = wr_arm;
    assign wr.deadline = sum_sat;
    cttq_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .wr           (wr),
      .in_valid     (c_valid[i]),
      .in_deadline  (c_dl[i]),
      .in_idx       (c_idx[i]),
      .out_valid    (c_valid[i+1]),
      .out_deadline (c_dl[i+1]),
      .out_idx      (c_idx[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      num   <= '0;
      fin   <= 1'b0;
    end else begin
      if (cnt != CW'(SLOTS)) begin
        cnt <= cnt + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r <= req.cmd;
            now_r <= req.now_ms;
            cnt   <= '0;
            pend  <= 1'b0;
            num   <= '0;
            if ((req.cmd == cttq_pkg::CMD_EXPIRE) || (req.cmd == cttq_pkg::CMD_QUERY)) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            slot_r <= '0;
            left_r <= '0;
            if (cmd_r == cttq_pkg::CMD_QUERY) begin
              kind_r <= cttq_pkg::KIND_NEXT;
              last_r <= 1'b1;
              fin    <= 1'b1;
              state  <= S_OUT;
              if (!b_valid) begin
                left_r <= '1;
              end else if (b_dl > now_r) begin
                if (diff > cttq_pkg::TIME_W'(cttq_pkg::MAX_LEFT)) begin
                  left_r <= cttq_pkg::LEFT_W'(cttq_pkg::MAX_LEFT);
                end else begin
                  left_r <= cttq_pkg::LEFT_W'(diff);
                end
              end
            end else if (found) begin
              pend     <= 1'b1;
              pend_idx <= b_idx;
              num      <= num + 1'b1;
              cnt      <= '0;
              if (pend) begin
                kind_r <= cttq_pkg::KIND_EXPIRED;
                slot_r <= cttq_pkg::SLOT_W'(pend_idx);
                last_r <= 1'b0;
                fin    <= 1'b0;
                state  <= S_OUT;
              end
            end else begin
              kind_r <= pend ? cttq_pkg::KIND_EXPIRED : cttq_pkg::KIND_NONE;
              slot_r <= pend ? cttq_pkg::SLOT_W'(pend_idx) : '0;
              last_r <= 1'b1;
              fin    <= 1'b1;
              state  <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= fin ? S_IDLE : S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request taken while a result is pending");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.result_kind == cttq_pkg::KIND_NONE)) |-> rsp.last)
    else $error("nothing-expired result without last");

  a_query_waits: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd == cttq_pkg::CMD_QUERY)) |=> !rsp.valid)
    else $error("query answered before the chain settled");

  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.result_kind != cttq_pkg::KIND_NEXT)) |-> (rsp.ms_to_next == '0))
    else $error("time left set on an expiry result");

endmodule
